FILE: rtl/core/oaht_pkg.sv
// Shared types, codes and constants for the open-addressing hash table core.
// No dependencies; every other file of the core imports this package.
package oaht_pkg;

	localparam int TS_W     = 7;
	localparam int KEY_W    = 64;
	localparam int HASH_W   = 32;
	localparam int VAL_W    = 32;
	localparam int OP_W     = 2;
	localparam int ST_W     = 2;

	localparam int DEF_TABLE_DEPTH = 64;
	localparam int DEF_KEY_BYTES   = 8;

	localparam logic [TS_W-1:0] TABLE_SIZE_RST = 7'd64;

	localparam int HASH_SHIFT     = 2;
	localparam int DIV_RADIX_BITS = 4;
	localparam int DIV_STEPS      = HASH_W / DIV_RADIX_BITS;

	localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
	localparam logic [OP_W-1:0] OP_GET    = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

	localparam logic [ST_W-1:0] ST_EMPTY   = 2'd0;
	localparam logic [ST_W-1:0] ST_SET     = 2'd1;
	localparam logic [ST_W-1:0] ST_DELETED = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            zero_key;
	} req_ctl_t;

	function automatic int idx_w(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

	function automatic int cnt_w(input int depth);
		return ($clog2(depth + 1) > TS_W) ? $clog2(depth + 1) : TS_W;
	endfunction

endpackage

FILE: rtl/core/oaht_if.sv
// Channel interfaces of the hash table core: request, response, table size write.
// Depends on oaht_pkg for field widths.
interface oaht_in_if import oaht_pkg::*;;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   opcode;
	logic [KEY_W-1:0]  key;
	logic [HASH_W-1:0] key_hash;
	logic [VAL_W-1:0]  payload;

	modport source (output valid, output opcode, output key, output key_hash,
		output payload, input ready);
	modport sink (input valid, input opcode, input key, input key_hash,
		input payload, output ready);
endinterface

interface oaht_out_if import oaht_pkg::*;;
	logic             valid;
	logic             ready;
	logic             ok;
	logic [VAL_W-1:0] read_value;

	modport source (output valid, output ok, output read_value, input ready);
	modport sink (input valid, input ok, input read_value, output ready);
endinterface

interface oaht_cfg_if import oaht_pkg::*;;
	logic            valid;
	logic            ready;
	logic [TS_W-1:0] table_size;

	modport source (output valid, output table_size, input ready);
	modport sink (input valid, input table_size, output ready);
endinterface

FILE: rtl/core/oaht_front.sv
// Front end: accepts request transactions and computes the start slot
// (key_hash / 4) mod live size, four quotient bits a cycle. Uses oaht_pkg, oaht_if.
module oaht_front import oaht_pkg::*; #(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int KEY_BYTES   = DEF_KEY_BYTES,
	localparam int IW = idx_w(TABLE_DEPTH),
	localparam int CW = cnt_w(TABLE_DEPTH),
	localparam int KW = 8 * KEY_BYTES
) (
	input  logic           clk,
	input  logic           arst_n,
	oaht_in_if.sink        in_ch,
	input  logic           init_busy,
	input  logic [CW-1:0]  live_n,
	input  logic           room,
	output logic           push,
	output req_ctl_t       ctl,
	output logic [KW-1:0]  key,
	output logic [VAL_W-1:0] payload,
	output logic [IW-1:0]  start
);

	localparam int SW = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

	logic              busy_q;
	logic              div_done_q;
	logic [SW-1:0]     cnt_q;
	logic [HASH_W-1:0] dividend_q;
	logic [CW-1:0]     rem_q;
	logic [CW-1:0]     rem_nx;
	req_ctl_t          ctl_q;
	logic [KW-1:0]     key_q;
	logic [VAL_W-1:0]  payload_q;
	logic              accept;

	assign in_ch.ready = !busy_q && !init_busy;
	assign accept      = in_ch.valid && in_ch.ready;
	assign push        = busy_q && div_done_q && room;
	assign ctl         = ctl_q;
	assign key         = key_q;
	assign payload     = payload_q;
	assign start       = rem_q[IW-1:0];

	always_comb begin
		logic [CW:0] r;
		r = {1'b0, rem_q};
		for (int k = 0; k < DIV_RADIX_BITS; k++) begin
			r = {r[CW-1:0], dividend_q[HASH_W-1-k]};
			if (r >= {1'b0, live_n}) begin
				r = r - {1'b0, live_n};
			end
		end
		rem_nx = r[CW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			div_done_q <= 1'b0;
			cnt_q      <= '0;
		end else if (accept) begin
			busy_q     <= 1'b1;
			div_done_q <= 1'b0;
			cnt_q      <= '0;
		end else if (busy_q && !div_done_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == SW'(DIV_STEPS - 1)) begin
				div_done_q <= 1'b1;
			end
		end else if (push) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dividend_q   <= {{HASH_SHIFT{1'b0}}, in_ch.key_hash[HASH_W-1:HASH_SHIFT]};
			rem_q        <= '0;
			ctl_q.op     <= in_ch.opcode;
			ctl_q.zero_key <= (in_ch.key[KW-1:0] == '0);
			key_q        <= in_ch.key[KW-1:0];
			payload_q    <= in_ch.payload;
		end else if (busy_q && !div_done_q) begin
			dividend_q <= dividend_q << DIV_RADIX_BITS;
			rem_q      <= rem_nx;
		end
	end

endmodule

FILE: rtl/core/oaht_queue.sv
// Two-entry queue between the front end and the probe engine.
// Uses oaht_pkg only for the shared style; payload is a plain vector.
module oaht_queue import oaht_pkg::*; #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         room,
	input  logic         pop,
	output logic         nonempty,
	output logic [W-1:0] rdata
);

	logic [W-1:0] ent_q [2];
	logic         wp_q;
	logic         rp_q;
	logic [1:0]   cnt_q;

	assign room     = (cnt_q != 2'd2);
	assign nonempty = (cnt_q != 2'd0);
	assign rdata    = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= wdata;
		end
	end

endmodule

FILE: rtl/core/oaht_back.sv
// Probe engine: owns the slot memory, runs linear probes, clear sweeps and
// the reset sweep, and holds the response register. Uses oaht_pkg, oaht_if.
module oaht_back import oaht_pkg::*; #(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int KEY_BYTES   = DEF_KEY_BYTES,
	localparam int IW = idx_w(TABLE_DEPTH),
	localparam int CW = cnt_w(TABLE_DEPTH),
	localparam int KW = 8 * KEY_BYTES
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CW-1:0]    live_n,
	input  logic             q_valid,
	input  req_ctl_t         q_ctl,
	input  logic [KW-1:0]    q_key,
	input  logic [VAL_W-1:0] q_payload,
	input  logic [IW-1:0]    q_start,
	output logic             q_pop,
	oaht_out_if.source       out_ch,
	output logic             init_busy,
	output logic             rsp_load
);

	localparam int MW = ST_W + KW + VAL_W;

	localparam logic [2:0] S_INIT = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_EV   = 3'd3;
	localparam logic [2:0] S_CLR  = 3'd4;
	localparam logic [2:0] S_RSP  = 3'd5;

	logic [2:0]       state_q;
	req_ctl_t         ctl_q;
	logic [KW-1:0]    key_q;
	logic [VAL_W-1:0] pay_q;
	logic [IW-1:0]    cur_q;
	logic [CW-1:0]    cnt_q;
	logic [IW-1:0]    sweep_q;
	logic             ok_q;
	logic [VAL_W-1:0] rv_q;
	logic             out_vld_q;
	logic             out_ok_q;
	logic [VAL_W-1:0] out_rv_q;

	logic [MW-1:0]    mem [TABLE_DEPTH];
	logic [MW-1:0]    rdata_q;

	logic [ST_W-1:0]  rd_st;
	logic [KW-1:0]    rd_key;
	logic [VAL_W-1:0] rd_val;
	logic             sweeping;
	logic             sweep_last;
	logic             ev_done;
	logic             ev_ok;
	logic [VAL_W-1:0] ev_rv;
	logic             ev_wr;
	logic [MW-1:0]    ev_wdata;
	logic             last_probe;
	logic [IW-1:0]    cur_nx;
	logic             we;
	logic [IW-1:0]    waddr;
	logic [MW-1:0]    wdata;

	assign rd_st  = rdata_q[MW-1 -: ST_W];
	assign rd_key = rdata_q[VAL_W +: KW];
	assign rd_val = rdata_q[VAL_W-1:0];

	assign init_busy  = (state_q == S_INIT);
	assign sweeping   = (state_q == S_INIT) || (state_q == S_CLR);
	assign sweep_last = (sweep_q == IW'(TABLE_DEPTH - 1));
	assign q_pop      = (state_q == S_IDLE) && q_valid;
	assign rsp_load   = (state_q == S_RSP) && (!out_vld_q || out_ch.ready);
	assign last_probe = ((cnt_q + 1'b1) == live_n);
	assign cur_nx     = ((CW'(cur_q) + 1'b1) == live_n) ? '0 : cur_q + 1'b1;

	assign out_ch.valid      = out_vld_q;
	assign out_ch.ok         = out_ok_q;
	assign out_ch.read_value = out_rv_q;

	always_comb begin
		ev_done  = 1'b0;
		ev_ok    = 1'b0;
		ev_rv    = '0;
		ev_wr    = 1'b0;
		ev_wdata = {ST_SET, key_q, pay_q};
		unique case (ctl_q.op)
			OP_ADD: begin
				if (rd_st != ST_SET) begin
					ev_done = 1'b1;
					ev_ok   = 1'b1;
					ev_wr   = 1'b1;
				end
			end
			OP_GET: begin
				if (rd_st == ST_EMPTY) begin
					ev_done = 1'b1;
				end else if (rd_st == ST_SET && rd_key == key_q) begin
					ev_done = 1'b1;
					ev_ok   = 1'b1;
					ev_rv   = rd_val;
				end
			end
			default: begin
				ev_ok    = 1'b1;
				ev_wdata = {ST_DELETED, {KW{1'b0}}, {VAL_W{1'b0}}};
				if (rd_st == ST_EMPTY) begin
					ev_done = 1'b1;
				end else if (rd_st == ST_SET && rd_key == key_q) begin
					ev_done = 1'b1;
					ev_wr   = 1'b1;
				end
			end
		endcase
		if (!ev_done && last_probe) begin
			ev_done = 1'b1;
			ev_ok   = (ctl_q.op == OP_REMOVE);
			ev_rv   = '0;
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = cur_q;
		wdata = ev_wdata;
		if (sweeping) begin
			we    = 1'b1;
			waddr = sweep_q;
			wdata = {ST_EMPTY, {KW{1'b0}}, {VAL_W{1'b0}}};
		end else if (state_q == S_EV) begin
			we = ev_wr;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[cur_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_INIT;
			sweep_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				out_vld_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_last) begin
						sweep_q <= '0;
						state_q <= S_IDLE;
					end
				end
				S_CLR: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_last) begin
						sweep_q <= '0;
						state_q <= S_RSP;
					end
				end
				S_IDLE: begin
					if (q_valid) begin
						priority if (q_ctl.op == OP_CLEAR) begin
							state_q <= S_CLR;
						end else if (q_ctl.op == OP_GET && q_ctl.zero_key) begin
							state_q <= S_RSP;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= S_EV;
				end
				S_EV: begin
					state_q <= ev_done ? S_RSP : S_RD;
				end
				S_RSP: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ctl_q <= q_ctl;
			key_q <= q_key;
			pay_q <= q_payload;
			cur_q <= q_start;
			cnt_q <= '0;
			ok_q  <= (q_ctl.op == OP_CLEAR);
			rv_q  <= '0;
		end else if (state_q == S_EV) begin
			ok_q <= ev_ok;
			rv_q <= ev_rv;
			if (!ev_done) begin
				cur_q <= cur_nx;
				cnt_q <= cnt_q + 1'b1;
			end
		end
		if (rsp_load) begin
			out_ok_q <= ok_q;
			out_rv_q <= rv_q;
		end
	end

endmodule

FILE: rtl/core/open_addressing_hash_table_core.sv
// Top level of the open-addressing hash table core: table size register,
// front end, request queue and probe engine. Uses oaht_pkg, oaht_if and the oaht_* modules.
//
//  channel  role  transaction carries
//  in_ch    sink  opcode, key, key_hash, payload
//  out_ch   src   ok, read_value
//  cfg      sink  table_size (always ready)
//
// Front end: load, then remainder steps of 4 bits each, then hand-off, held while the
// queue is full; it works on the next request while the probe engine runs.
// Probe engine: each slot visited is a registered memory read, then a compare; a
// request is dequeued, probed and answered; a clear sweeps all TABLE_DEPTH slots.
// After reset all TABLE_DEPTH slots are swept empty; in_ch.ready stays low during the sweep.
// A stalled out_ch holds one response; the queue absorbs two more requests.
module open_addressing_hash_table_core import oaht_pkg::*; #(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int KEY_BYTES   = DEF_KEY_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	oaht_in_if.sink     in_ch,
	oaht_out_if.source  out_ch,
	oaht_cfg_if.sink    cfg
);

	localparam int IW = idx_w(TABLE_DEPTH);
	localparam int CW = cnt_w(TABLE_DEPTH);
	localparam int KW = 8 * KEY_BYTES;
	localparam int QW = $bits(req_ctl_t) + KW + VAL_W + IW;

	logic [TS_W-1:0]  table_size_q;
	logic [CW-1:0]    ts_ext;
	logic [CW-1:0]    live_n;
	logic             init_busy;
	logic             f_push;
	logic             q_room;
	req_ctl_t         f_ctl;
	logic [KW-1:0]    f_key;
	logic [VAL_W-1:0] f_payload;
	logic [IW-1:0]    f_start;
	logic [QW-1:0]    q_rdata;
	logic             q_valid;
	logic             q_pop;
	logic             rsp_load;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= TABLE_SIZE_RST;
		end else if (cfg.valid) begin
			table_size_q <= cfg.table_size;
		end
	end

	assign ts_ext = CW'(table_size_q);

	always_comb begin
		priority if (ts_ext == '0) begin
			live_n = CW'(1);
		end else if (ts_ext > CW'(TABLE_DEPTH)) begin
			live_n = CW'(TABLE_DEPTH);
		end else begin
			live_n = ts_ext;
		end
	end

	oaht_front #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.KEY_BYTES   (KEY_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.init_busy (init_busy),
		.live_n    (live_n),
		.room      (q_room),
		.push      (f_push),
		.ctl       (f_ctl),
		.key       (f_key),
		.payload   (f_payload),
		.start     (f_start)
	);

	oaht_queue #(
		.W (QW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (f_push),
		.wdata    ({f_ctl, f_key, f_payload, f_start}),
		.room     (q_room),
		.pop      (q_pop),
		.nonempty (q_valid),
		.rdata    (q_rdata)
	);

	oaht_back #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.KEY_BYTES   (KEY_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.live_n    (live_n),
		.q_valid   (q_valid),
		.q_ctl     (q_rdata[QW-1 -: $bits(req_ctl_t)]),
		.q_key     (q_rdata[VAL_W + IW +: KW]),
		.q_payload (q_rdata[IW +: VAL_W]),
		.q_start   (q_rdata[IW-1:0]),
		.q_pop     (q_pop),
		.out_ch    (out_ch),
		.init_busy (init_busy),
		.rsp_load  (rsp_load)
	);

`ifndef SYNTHESIS
	a_no_accept_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |-> !in_ch.ready)
		else $error("request accepted during reset sweep");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		f_push |-> q_room)
		else $error("queue push while full");

	a_pop_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue pop while empty");

	a_rsp_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |-> (!out_ch.valid || out_ch.ready))
		else $error("response register overwritten");
`endif

endmodule
